/* sv/crcmb_pkg.sv */
// Shared types, constants and CRC fold function for the CRC-16 frame trailer block.
package crcmb_pkg;

	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned CRC_W         = 16;
	localparam int unsigned CNT_W         = 3;
	localparam int unsigned PAYLOAD_BYTES = 8;

	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

	typedef enum logic [1:0] {
		PH_DATA,
		PH_CRC_LO,
		PH_CRC_HI
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic [CRC_W-1:0]  crc;
		logic              last;
	} entry_t;

	function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

/* sv/crc16_modbus_frame_appender_core.sv */
// Top level of the CRC-16 (reflected 0xA001, init 0xFFFF) frame trailer block.
// Payload bytes pass unchanged through the registered request stage; each frame of
// PAYLOAD_BYTES bytes is followed by the CRC low byte and then the CRC high byte, the
// latter flagged with frame_end. The input accepts one byte per cycle while the output
// drains, but the last byte of a frame occupies the single request register until it and
// both CRC bytes have been sent, so the input is held until the CRC high byte is taken.
// The CRC and byte count restart on their own after each frame.
module crc16_modbus_frame_appender_core #(
	parameter int unsigned PAYLOAD_BYTES = crcmb_pkg::PAYLOAD_BYTES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [crcmb_pkg::BYTE_W-1:0]  data_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [crcmb_pkg::BYTE_W-1:0]  tx_byte,
	output logic                          frame_end
);
	import crcmb_pkg::*;

	logic   valid_s1;
	entry_t entry_s1;
	logic   take;

	crcmb_frame #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.data_byte(data_byte),
		.take     (take),
		.valid_s1 (valid_s1),
		.entry_s1 (entry_s1)
	);

	crcmb_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.entry_s1 (entry_s1),
		.take     (take),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.tx_byte  (tx_byte),
		.frame_end(frame_end)
	);

endmodule

/* sv/crcmb_frame.sv */
// Frame tracker: running CRC, byte count and the registered request stage.
module crcmb_frame #(
	parameter int unsigned PAYLOAD_BYTES = crcmb_pkg::PAYLOAD_BYTES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [crcmb_pkg::BYTE_W-1:0]  data_byte,
	input  logic                          take,
	output logic                          valid_s1,
	output crcmb_pkg::entry_t             entry_s1
);
	import crcmb_pkg::*;

	logic [CRC_W-1:0] crc_q;
	logic [CNT_W-1:0] count_q;
	logic [CRC_W-1:0] crc_next;
	logic [CNT_W:0]   taken;
	logic             last;
	logic             accept;

	assign crc_next = crc_fold(crc_q, data_byte);
	assign taken    = {1'b0, count_q} + {{CNT_W{1'b0}}, 1'b1};
	assign last     = taken >= (CNT_W+1)'(PAYLOAD_BYTES);
	assign in_ready = !valid_s1 || take;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= CRC_INIT;
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (last) begin
					crc_q   <= CRC_INIT;
					count_q <= '0;
				end else begin
					crc_q   <= crc_next;
					count_q <= taken[CNT_W-1:0];
				end
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1.data <= data_byte;
			entry_s1.crc  <= crc_next;
			entry_s1.last <= last;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, count_q} < (CNT_W+1)'(PAYLOAD_BYTES)))
		else $error("byte count beyond frame length");

endmodule

/* sv/crcmb_emit.sv */
// Output sequencer: payload byte, then CRC low and high bytes on the last byte of a frame.
module crcmb_emit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s1,
	input  crcmb_pkg::entry_t             entry_s1,
	output logic                          take,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [crcmb_pkg::BYTE_W-1:0]  tx_byte,
	output logic                          frame_end
);
	import crcmb_pkg::*;

	phase_t phase_q;
	phase_t phase_next;
	logic   fire;

	assign fire = valid_s1 && out_ready;

	always_comb begin
		phase_next = phase_q;
		if (fire) begin
			case (phase_q)
				PH_DATA:   phase_next = entry_s1.last ? PH_CRC_LO : PH_DATA;
				PH_CRC_LO: phase_next = PH_CRC_HI;
				PH_CRC_HI: phase_next = PH_DATA;
				default:   phase_next = PH_DATA;
			endcase
		end
	end

	always_comb begin
		out_valid = valid_s1;
		frame_end = 1'b0;
		take      = 1'b0;
		case (phase_q)
			PH_DATA: begin
				tx_byte = entry_s1.data;
				take    = fire && !entry_s1.last;
			end
			PH_CRC_LO: begin
				tx_byte = entry_s1.crc[BYTE_W-1:0];
			end
			PH_CRC_HI: begin
				tx_byte   = entry_s1.crc[CRC_W-1:BYTE_W];
				frame_end = 1'b1;
				take      = fire;
			end
			default: begin
				tx_byte = entry_s1.data;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DATA;
		end else begin
			phase_q <= phase_next;
		end
	end

	a_trailer_needs_request: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_DATA) |-> (valid_s1 && entry_s1.last))
		else $error("trailer phase without a closing request");

	a_stall_holds_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_ready) |=> $stable(phase_q))
		else $error("phase advanced while stalled");

	a_end_releases: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && frame_end) |=> (phase_q == PH_DATA))
		else $error("frame end did not return to payload phase");

	a_take_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (fire && (frame_end || !entry_s1.last)))
		else $error("request released before its last byte");

endmodule

/* bench/tb.sv */
// Self-checking bench for the CRC-16 Modbus frame trailer core.
`timescale 1ns / 100ps

module tb #(
	parameter int unsigned FRAME_LEN = crcmb_pkg::PAYLOAD_BYTES
);

	import crcmb_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0] tx;
		logic              last;
	} tx_item_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	logic [BYTE_W-1:0] data_byte = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [BYTE_W-1:0] tx_byte;
	logic              frame_end;

	logic [BYTE_W-1:0] pending_bytes[$];
	tx_item_t          tx_expect[$];

	logic [CRC_W-1:0]  crc_acc     = CRC_INIT;
	logic [CNT_W-1:0]  bytes_taken = '0;

	int unsigned sent_cnt     = 0;
	int unsigned frames_sent  = 0;
	int unsigned checked_cnt  = 0;
	int unsigned frames_seen  = 0;
	int unsigned mismatches   = 0;
	bit          hold_on      = 1'b0;

	crc16_modbus_frame_appender_core #(
		.PAYLOAD_BYTES(FRAME_LEN)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.tx_byte   (tx_byte),
		.frame_end (frame_end)
	);

	function automatic logic [CRC_W-1:0] crc16_mb_update(input logic [CRC_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] r;
		logic             lsb;
		r = crc;
		for (int i = 0; i < BYTE_W; i++) begin
			lsb = r[0] ^ b[i];
			r = r >> 1;
			if (lsb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	task automatic fold_request(input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] crc;
		crc = crc16_mb_update(crc_acc, b);
		tx_expect.push_back(tx_item_t'{tx: b, last: 1'b0});
		if (int'(bytes_taken) + 1 >= int'(FRAME_LEN)) begin
			tx_expect.push_back(tx_item_t'{tx: crc[7:0], last: 1'b0});
			tx_expect.push_back(tx_item_t'{tx: crc[15:8], last: 1'b1});
			crc_acc = CRC_INIT;
			bytes_taken = '0;
			frames_sent++;
		end else begin
			crc_acc = crc;
			bytes_taken = bytes_taken + 1'b1;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#2_000_000;
		$display("crc16_modbus_frame_appender_core regression: fail");
		$finish;
	end

	// receiver hold: block the output for a long stretch once traffic is flowing
	initial begin
		wait (checked_cnt >= 200);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (80) @(posedge clk);
		hold_on <= 1'b0;
	end

	// driver: offer the next request, hold it until taken
	always @(posedge clk or negedge arst_n) begin
		bit quiet;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			data_byte <= '0;
		end else begin
			if (in_valid && in_ready) begin
				fold_request(data_byte);
				sent_cnt++;
			end
			if (!in_valid || in_ready) begin
				quiet = (sent_cnt >= 120) && (sent_cnt < 220);
				if (pending_bytes.size() > 0 && (quiet || $urandom_range(0, 99) >= 24)) begin
					in_valid  <= 1'b1;
					data_byte <= pending_bytes.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each transmit byte against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		tx_item_t want;
		bit       quiet;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				checked_cnt++;
				if (frame_end) begin
					frames_seen++;
				end
				if (tx_expect.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: unexpected byte %02h frame_end %0b", $time,
							tx_byte, frame_end);
					end
				end else begin
					want = tx_expect.pop_front();
					if (tx_byte !== want.tx || frame_end !== want.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: byte %0d expected %02h/%0b got %02h/%0b",
								$time, checked_cnt, want.tx, want.last, tx_byte, frame_end);
						end
					end
				end
			end
			if (hold_on) begin
				out_ready <= 1'b0;
			end else begin
				quiet = (checked_cnt >= 360) && (checked_cnt < 660);
				out_ready <= quiet || ($urandom_range(0, 99) >= 24);
			end
		end
	end

	initial begin
		logic [BYTE_W-1:0] b;
		for (int i = 0; i < 8; i++) begin
			pending_bytes.push_back(8'h00);
		end
		for (int i = 0; i < 8; i++) begin
			pending_bytes.push_back(8'hFF);
		end
		for (int i = 0; i < 8; i++) begin
			pending_bytes.push_back(8'h01 << i);
		end
		for (int i = 0; i < 356; i++) begin
			case ($urandom_range(0, 7))
				0: b = 8'h00;
				1: b = 8'hFF;
				default: b = 8'($urandom_range(0, 255));
			endcase
			pending_bytes.push_back(b);
		end

		while (pending_bytes.size() != 0 || in_valid) begin
			@(posedge clk);
		end
		while (tx_expect.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		mismatches += tx_expect.size();

		$display("sent %0d payload bytes (%0d full frames of %0d), checked %0d transmit bytes",
			sent_cnt, frames_sent, FRAME_LEN, checked_cnt);
		$display("frames closed on output %0d, mismatches %0d", frames_seen, mismatches);
		if (mismatches == 0) begin
			$display("crc16_modbus_frame_appender_core regression: pass");
		end else begin
			$display("crc16_modbus_frame_appender_core regression: fail");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/crcmb_pkg.sv
sv/crcmb_frame.sv
sv/crcmb_emit.sv
sv/crc16_modbus_frame_appender_core.sv
bench/tb.sv
